>>> design/bresenham_line_wrapped_top_defines.svh
// Assertion helpers for the checks in the line engine's top module.
`ifndef BRESENHAM_LINE_WRAPPED_TOP_DEFINES_SVH
`define BRESENHAM_LINE_WRAPPED_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define BLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> design/blw_pkg.sv
`timescale 1ns / 1ps

package blw_pkg;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } t_state;

    // Request command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Frame size after reset.
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic div_iter;
        logic fix;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
    } t_dp_status;

endpackage

>>> design/bresenham_line_wrapped_top.sv
`timescale 1ns / 1ps
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  request   | i_in_valid / o_in_ready   | i_command, i_start_x/y, i_end_x/y,
//            |                           | i_line_color
//  result    | o_out_valid / i_out_ready | o_pix_x, o_pix_y, o_pix_addr, o_pix_color,
//            |                           | o_last_pixel
//  config    | i_cfg_we (no wait)        | i_cfg_index, i_cfg_wdata
//
//  A load request, and a step request with no active line, finish in the idle state.
//  A step request on an active line runs through the divide, fix and output states:
//  the wrap unit reduces both coordinates one remainder bit per cycle, then the fix
//  state corrects negative values and the output state loads the result register.
//  Reset is synchronous and active low; it restores a 640 x 480 frame and idles.
//  A result waiting on i_out_ready holds the engine in its output state, but the
//  next request is taken as soon as the result register is free.
`include "bresenham_line_wrapped_top_defines.svh"

module bresenham_line_wrapped_top #(
    parameter int COORD_BITS = 12,
    parameter int MAX_DIM    = 1024,
    localparam int DIM_W     = $clog2(MAX_DIM),
    localparam int CFG_W     = DIM_W + 1,
    localparam int ADDR_W    = 2 * DIM_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel.
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic [31:0]                  i_line_color,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [DIM_W-1:0]             o_pix_x,
    output logic [DIM_W-1:0]             o_pix_y,
    output logic [ADDR_W-1:0]            o_pix_addr,
    output logic [31:0]                  o_pix_color,
    output logic                         o_last_pixel,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_wdata
);

    blw_pkg::t_dp_cmd    w_cmd;
    blw_pkg::t_dp_status w_status;

    // The controller sequences each step through the shared wrap unit.
    blw_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the line state, the frame size and the result register.
    blw_dp #(
        .COORD_BITS (COORD_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_line_color (i_line_color),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_pix_x      (o_pix_x),
        .o_pix_y      (o_pix_y),
        .o_pix_addr   (o_pix_addr),
        .o_pix_color  (o_pix_color),
        .o_last_pixel (o_last_pixel)
    );

    // A load always leaves an active line behind it.
    `BLW_ASSERT_NEXT(a_load_sets_busy, i_clk, i_rst_n, w_cmd.load, w_status.busy)

    // A step on an active line occupies the engine in the following cycle.
    `BLW_ASSERT_NEXT(a_step_blocks_requests, i_clk, i_rst_n, w_cmd.step, !o_in_ready)

    // A new result never overwrites one that has not been taken.
    `BLW_ASSERT_IMPL(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.out_load,
                     (!o_out_valid || i_out_ready))

endmodule

>>> design/blw_ctrl.sv
`timescale 1ns / 1ps

module blw_ctrl #(
    parameter int COORD_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_command,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  blw_pkg::t_dp_status  i_status,
    output blw_pkg::t_dp_cmd     o_cmd
);

    localparam int CNT_W = $clog2(COORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_BITS - 1);

    blw_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blw_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            blw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_command == blw_pkg::CMD_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_status.busy) begin
                        o_cmd.step = 1'b1;
                        n_cnt      = '0;
                        n_state    = blw_pkg::ST_DIV;
                    end
                end
            end
            blw_pkg::ST_DIV: begin
                o_cmd.div_iter = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = blw_pkg::ST_FIX;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            blw_pkg::ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = blw_pkg::ST_OUT;
            end
            blw_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = blw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = blw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> design/blw_dp.sv
`timescale 1ns / 1ps

module blw_dp #(
    parameter int COORD_BITS = 12,
    parameter int MAX_DIM    = 1024,
    localparam int DIM_W     = $clog2(MAX_DIM),
    localparam int CFG_W     = DIM_W + 1,
    localparam int ADDR_W    = 2 * DIM_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic [31:0]                  i_line_color,
    input  blw_pkg::t_dp_cmd             i_cmd,
    output blw_pkg::t_dp_status          o_status,
    output logic [DIM_W-1:0]             o_pix_x,
    output logic [DIM_W-1:0]             o_pix_y,
    output logic [ADDR_W-1:0]            o_pix_addr,
    output logic [31:0]                  o_pix_color,
    output logic                         o_last_pixel
);

    localparam int C = COORD_BITS;
    localparam int W_RST = (blw_pkg::FRAME_WIDTH_RST > MAX_DIM) ?
                           MAX_DIM : blw_pkg::FRAME_WIDTH_RST;
    localparam int H_RST = (blw_pkg::FRAME_HEIGHT_RST > MAX_DIM) ?
                           MAX_DIM : blw_pkg::FRAME_HEIGHT_RST;

    // Frame size registers.
    logic [CFG_W-1:0] r_frame_w, r_frame_h;
    logic [CFG_W-1:0] w_eff_w, w_eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= CFG_W'(W_RST);
            r_frame_h <= CFG_W'(H_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                blw_pkg::REG_FRAME_WIDTH:  r_frame_w <= i_cfg_wdata;
                blw_pkg::REG_FRAME_HEIGHT: r_frame_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A zero size acts as one, an oversized one as the maximum.
    assign w_eff_w = (r_frame_w == '0) ? CFG_W'(1) :
                     (r_frame_w > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : r_frame_w;
    assign w_eff_h = (r_frame_h == '0) ? CFG_W'(1) :
                     (r_frame_h > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : r_frame_h;

    // Line state.
    logic                r_busy;
    logic signed [C-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [C:0]          r_dx;
    logic signed [C+1:0] r_ndy;
    logic                r_sxn, r_syn;
    logic signed [C+2:0] r_err;
    logic [31:0]         r_color;

    // Setup arithmetic for a load.
    logic signed [C:0]   w_diff_x, w_diff_y;
    logic [C:0]          w_abs_dx, w_abs_dy;
    logic signed [C+1:0] w_ndy;
    logic signed [C+2:0] w_err0;

    assign w_diff_x = (C+1)'(i_end_x) - (C+1)'(i_start_x);
    assign w_diff_y = (C+1)'(i_end_y) - (C+1)'(i_start_y);
    assign w_abs_dx = w_diff_x[C] ? (C+1)'(-w_diff_x) : (C+1)'(w_diff_x);
    assign w_abs_dy = w_diff_y[C] ? (C+1)'(-w_diff_y) : (C+1)'(w_diff_y);
    assign w_ndy    = -$signed({1'b0, w_abs_dy});
    assign w_err0   = $signed((C+3)'({1'b0, w_abs_dx})) + (C+3)'(w_ndy);

    // One Bresenham step.
    logic signed [C+3:0] w_e2;
    logic                w_ge, w_le, w_last;
    logic signed [C+2:0] w_add_x, w_add_y, w_err_n;

    assign w_e2    = $signed({r_err, 1'b0});
    assign w_ge    = w_e2 >= (C+4)'(r_ndy);
    assign w_le    = w_e2 <= $signed((C+4)'({1'b0, r_dx}));
    assign w_add_x = w_ge ? (C+3)'(r_ndy) : '0;
    assign w_add_y = w_le ? $signed((C+3)'({1'b0, r_dx})) : '0;
    assign w_err_n = r_err + w_add_x + w_add_y;
    assign w_last  = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.load) begin
            r_busy <= 1'b1;
        end else if (i_cmd.step && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x <= i_start_x;
            r_cur_y <= i_start_y;
            r_tgt_x <= i_end_x;
            r_tgt_y <= i_end_y;
            r_dx    <= w_abs_dx;
            r_ndy   <= w_ndy;
            r_sxn   <= !(i_start_x < i_end_x);
            r_syn   <= !(i_start_y < i_end_y);
            r_err   <= w_err0;
            r_color <= i_line_color;
        end else if (i_cmd.step && !w_last) begin
            r_err <= w_err_n;
            if (w_ge) begin
                r_cur_x <= r_sxn ? r_cur_x - C'(1) : r_cur_x + C'(1);
            end
            if (w_le) begin
                r_cur_y <= r_syn ? r_cur_y - C'(1) : r_cur_y + C'(1);
            end
        end
    end

    // Wrap unit: restoring remainder of the magnitude, one bit per cycle for
    // both axes, then a correction for negative coordinates.
    logic [CFG_W-1:0] r_w, r_h;
    logic [C-1:0]     r_mag_x, r_mag_y;
    logic             r_neg_x, r_neg_y;
    logic [CFG_W-1:0] r_rem_x, r_rem_y;
    logic             r_last;
    logic [CFG_W:0]   w_sh_x, w_sh_y;
    logic [CFG_W-1:0] w_rem_x, w_rem_y;

    assign w_sh_x  = {r_rem_x, r_mag_x[C-1]};
    assign w_sh_y  = {r_rem_y, r_mag_y[C-1]};
    assign w_rem_x = (w_sh_x >= {1'b0, r_w}) ? CFG_W'(w_sh_x - {1'b0, r_w}) : CFG_W'(w_sh_x);
    assign w_rem_y = (w_sh_y >= {1'b0, r_h}) ? CFG_W'(w_sh_y - {1'b0, r_h}) : CFG_W'(w_sh_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_w     <= w_eff_w;
            r_h     <= w_eff_h;
            r_neg_x <= r_cur_x[C-1];
            r_neg_y <= r_cur_y[C-1];
            r_mag_x <= r_cur_x[C-1] ? C'(-r_cur_x) : C'(r_cur_x);
            r_mag_y <= r_cur_y[C-1] ? C'(-r_cur_y) : C'(r_cur_y);
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_last  <= w_last;
        end else if (i_cmd.div_iter) begin
            r_rem_x <= w_rem_x;
            r_rem_y <= w_rem_y;
            r_mag_x <= r_mag_x << 1;
            r_mag_y <= r_mag_y << 1;
        end else if (i_cmd.fix) begin
            if (r_neg_x && (r_rem_x != '0)) begin
                r_rem_x <= r_w - r_rem_x;
            end
            if (r_neg_y && (r_rem_y != '0)) begin
                r_rem_y <= r_h - r_rem_y;
            end
        end
    end

    // Output register with the address multiply in front of it.
    logic [DIM_W+CFG_W-1:0] w_prod;

    assign w_prod = r_rem_y[DIM_W-1:0] * r_w + (DIM_W+CFG_W)'(r_rem_x[DIM_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pix_x      <= r_rem_x[DIM_W-1:0];
            o_pix_y      <= r_rem_y[DIM_W-1:0];
            o_pix_addr   <= ADDR_W'(w_prod);
            o_pix_color  <= r_color;
            o_last_pixel <= r_last;
        end
    end

    assign o_status.busy = r_busy;

endmodule
